[rtl/fermion_operator_sign_unit_assert.svh]
// ---------------------------------------------------------------------------
// fermion_operator_sign_unit_assert.svh
// Assertion macros used by the checker of the fermion operator sign unit.
// ---------------------------------------------------------------------------
`ifndef FERMION_OPERATOR_SIGN_UNIT_ASSERT_SVH
`define FERMION_OPERATOR_SIGN_UNIT_ASSERT_SVH

// Check a consequence a fixed number of cycles after a trigger.
`define FOSU_ASSERT_AFTER(lbl, clk, rst_n, lat, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
    (ante) |-> ##lat (cons)) else $error(msg);

// Check a condition at every clock edge out of reset.
`define FOSU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
    (cond)) else $error(msg);

`endif

[rtl/fosu_pkg.sv]
// ---------------------------------------------------------------------------
// fosu_pkg
// Types and constants of the fermion operator sign unit.
// ---------------------------------------------------------------------------
package fosu_pkg;

  // Width of an occupation string
  localparam int unsigned OCC_W = 64;
  // Partial parity groups in the first reduction stage
  localparam int unsigned PAR_GROUPS = 8;
  localparam int unsigned PAR_GW = OCC_W / PAR_GROUPS;

  // Operation codes; the last one does nothing
  typedef enum logic [1:0] {
    OP_ANNIHILATE = 2'd0,
    OP_CREATE     = 2'd1,
    OP_PHASE      = 2'd2,
    OP_NOP        = 2'd3
  } op_e;

  // Result fields that ride alongside the parity reduction
  typedef struct packed {
    logic [OCC_W-1:0] new_occ;
    logic             apply;
    logic             is_phase;
    logic             sign_in;
  } side_t;

endpackage

[rtl/fermion_operator_sign_unit.sv]
// ---------------------------------------------------------------------------
// fermion_operator_sign_unit
// Applies a fermionic create or annihilate operator at one site of an
// occupation string, or gives the phase between two strings. The unit takes
// one item per clock cycle (busy stays low) and shows its result on done_o
// once the item has passed its stages: three stages find the site masks
// and the two lowest differing sites, two stages reduce the parity, and one
// registers the result. Results cannot be held off and leave in the order
// the items came in. No clearing pass or other wait follows reset.
// ---------------------------------------------------------------------------
module fermion_operator_sign_unit #(
  parameter int unsigned SITES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] occupation_i,
  input  logic [63:0] other_occupation_i,
  input  logic [5:0]  site_index_i,
  input  logic        sign_in_negative_i,
  output logic        done_o,
  output logic [63:0] new_occupation_o,
  output logic        success_o,
  output logic        sign_out_negative_o
);

  localparam int unsigned W = fosu_pkg::OCC_W;
  localparam logic [W-1:0] SiteMask =
    (SITES >= W) ? {W{1'b1}} : ((W'(1) << SITES) - W'(1));
  localparam logic [6:0] SiteLimit = 7'(SITES);

  // Stage 1 signals
  fosu_pkg::op_e  op;
  logic [W-1:0]   site_bit, diff_d, d1_d;
  logic           site_ok, is_set, apply_d;
  logic           s1_valid_q;
  fosu_pkg::side_t s1_side_q;
  logic [W-1:0]   s1_occ_q, s1_below_q, s1_diff_q, s1_d1_q;

  // Stage 2 signals
  logic [W-1:0]   rest, d2_d, lo1_d;
  logic           s2_valid_q;
  fosu_pkg::side_t s2_side_q;
  logic [W-1:0]   s2_occ_q, s2_below_q, s2_d2_q, s2_lo1_q;

  // Stage 3 signals
  logic [W-1:0]   between, vec_d;
  logic           s3_valid_q;
  fosu_pkg::side_t s3_side_q;
  logic [W-1:0]   s3_vec_q;

  // Tree outputs and result register
  logic           t_valid;
  logic           t_par;
  fosu_pkg::side_t t_side;
  logic           sign_d;
  logic           done_q;
  logic [W-1:0]   new_occ_q;
  logic           success_q;
  logic           sign_q;

  // Stage 1: decode the site and isolate the lowest differing site
  always_comb begin
    op       = fosu_pkg::op_e'(opcode_i);
    site_bit = W'(1) << site_index_i;
    site_ok  = {1'b0, site_index_i} < SiteLimit;
    is_set   = |(occupation_i & site_bit);
    diff_d   = (occupation_i ^ other_occupation_i) & SiteMask;
    d1_d     = diff_d & (~diff_d + W'(1));
    unique case (op)
      fosu_pkg::OP_ANNIHILATE: apply_d = site_ok & is_set;
      fosu_pkg::OP_CREATE:     apply_d = site_ok & ~is_set;
      fosu_pkg::OP_PHASE:      apply_d = 1'b1;
      fosu_pkg::OP_NOP:        apply_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_side_q.apply    <= apply_d;
    s1_side_q.is_phase <= (op == fosu_pkg::OP_PHASE);
    s1_side_q.sign_in  <= sign_in_negative_i;
    s1_side_q.new_occ  <= (apply_d && op != fosu_pkg::OP_PHASE) ?
                          (occupation_i ^ site_bit) : occupation_i;
    s1_occ_q           <= occupation_i;
    s1_below_q         <= site_bit - W'(1);
    s1_diff_q          <= diff_d;
    s1_d1_q            <= d1_d;
  end

  // Stage 2: isolate the second differing site, mask up to the first
  always_comb begin
    rest  = s1_diff_q & ~s1_d1_q;
    d2_d  = rest & (~rest + W'(1));
    lo1_d = s1_d1_q | (s1_d1_q - W'(1));
  end

  always_ff @(posedge clk_i) begin
    s2_side_q  <= s1_side_q;
    s2_occ_q   <= s1_occ_q;
    s2_below_q <= s1_below_q;
    s2_d2_q    <= d2_d;
    s2_lo1_q   <= lo1_d;
  end

  // Stage 3: select the bits whose parity sets the sign
  always_comb begin
    between = (s2_d2_q - W'(1)) & ~s2_lo1_q & {W{|s2_d2_q}};
    vec_d   = s2_occ_q & (s2_side_q.is_phase ? between : s2_below_q);
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= s2_side_q;
    s3_vec_q  <= vec_d;
  end

  // Advance valid bits through the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Stages 4 and 5: parity reduction
  fosu_parity_tree u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid_q),
    .vec_i   (s3_vec_q),
    .side_i  (s3_side_q),
    .valid_o (t_valid),
    .par_o   (t_par),
    .side_o  (t_side)
  );

  // Stage 6: form the sign and register the result
  assign sign_d = t_side.is_phase ? t_par : (t_side.sign_in ^ (t_side.apply & t_par));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= t_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    new_occ_q <= t_side.new_occ;
    success_q <= t_side.apply;
    sign_q    <= sign_d;
  end

  assign busy                = 1'b0;
  assign done_o              = done_q;
  assign new_occupation_o    = new_occ_q;
  assign success_o           = success_q;
  assign sign_out_negative_o = sign_q;

endmodule

[rtl/fosu_parity_tree.sv]
// ---------------------------------------------------------------------------
// fosu_parity_tree
// Two-stage registered parity of a 64-bit vector; side fields travel along.
// ---------------------------------------------------------------------------
module fosu_parity_tree (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [fosu_pkg::OCC_W-1:0] vec_i,
  input  fosu_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic                       par_o,
  output fosu_pkg::side_t            side_o
);

  logic                              valid_a_q;
  logic [fosu_pkg::PAR_GROUPS-1:0]   part_d, part_q;
  fosu_pkg::side_t                   side_a_q;
  logic                              valid_b_q;
  logic                              par_q;
  fosu_pkg::side_t                   side_b_q;

  // Reduce each byte group to one parity bit
  always_comb begin
    for (int g = 0; g < int'(fosu_pkg::PAR_GROUPS); g++) begin
      part_d[g] = ^vec_i[g*fosu_pkg::PAR_GW +: fosu_pkg::PAR_GW];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  // Hold partial and final parities with their side fields
  always_ff @(posedge clk_i) begin
    part_q   <= part_d;
    side_a_q <= side_i;
    par_q    <= ^part_q;
    side_b_q <= side_a_q;
  end

  assign valid_o = valid_b_q;
  assign par_o   = par_q;
  assign side_o  = side_b_q;

endmodule

[rtl/fosu_checker.sv]
// ---------------------------------------------------------------------------
// fosu_checker
// Port-level checks of the fermion operator sign unit, bound to the top.
// ---------------------------------------------------------------------------
`include "fermion_operator_sign_unit_assert.svh"

module fosu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic [63:0] occupation_i,
  input logic        done_o,
  input logic [63:0] new_occupation_o,
  input logic        success_o
);

  localparam int unsigned LAT = 6;

  // A transfer yields a result after the fixed latency
  `FOSU_ASSERT_AFTER(a_result_follows, clk_i, rst_ni, LAT,
    start && !busy, done_o, "missing result")

  // No transfer, no result
  `FOSU_ASSERT_AFTER(a_no_spurious, clk_i, rst_ni, LAT,
    !(start && !busy), !done_o, "spurious result")

  // Phase always succeeds and leaves the string alone
  `FOSU_ASSERT_AFTER(a_phase_ok, clk_i, rst_ni, LAT,
    start && !busy && opcode_i == fosu_pkg::OP_PHASE,
    success_o && new_occupation_o == $past(occupation_i, LAT), "phase result wrong")

  // The unused code does nothing
  `FOSU_ASSERT_AFTER(a_nop, clk_i, rst_ni, LAT,
    start && !busy && opcode_i == fosu_pkg::OP_NOP,
    !success_o && new_occupation_o == $past(occupation_i, LAT), "unused opcode acted")

endmodule

bind fermion_operator_sign_unit fosu_checker u_fosu_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .opcode_i         (opcode_i),
  .occupation_i     (occupation_i),
  .done_o           (done_o),
  .new_occupation_o (new_occupation_o),
  .success_o        (success_o)
);

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for fermion_operator_sign_unit. A queue of commands
// (a directed set of corner cases followed by shaped random ones) feeds a
// clocked driver that idles at a rate that changes by phase. A clocked
// monitor compares every done_o strobe against an in-order queue of
// predicted operator results.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SITES       = 64;
  localparam int unsigned RANDOM_CMDS = 440;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam logic [63:0] SITE_MASK   =
    (SITES >= 64) ? {64{1'b1}} : ((64'd1 << SITES) - 64'd1);

  // One command as presented to the unit, plus pacing controls
  typedef struct {
    logic [1:0]  opcode;
    logic [63:0] occ;
    logic [63:0] other;
    logic [5:0]  site;
    logic        sign_neg;
    int unsigned pace;
    bit          drain_first;
  } occ_cmd_t;

  // One result of an operator
  typedef struct {
    logic [63:0] occ;
    logic        ok;
    logic        sign_neg;
  } op_result_t;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        start              = 1'b0;
  logic [1:0]  opcode_i           = '0;
  logic [63:0] occupation_i       = '0;
  logic [63:0] other_occupation_i = '0;
  logic [5:0]  site_index_i       = '0;
  logic        sign_in_negative_i = 1'b0;
  logic        busy;
  logic        done_o;
  logic [63:0] new_occupation_o;
  logic        success_o;
  logic        sign_out_negative_o;

  occ_cmd_t    cmd_q[$];
  op_result_t  result_q[$];
  int unsigned idle_pct[3] = '{21, 45, 0};
  int unsigned mismatches  = 0;
  int unsigned checked     = 0;
  int unsigned op_seen[4]  = '{0, 0, 0, 0};
  int unsigned cycle_cnt   = 0;

  fermion_operator_sign_unit #(
    .SITES(SITES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .occupation_i       (occupation_i),
    .other_occupation_i (other_occupation_i),
    .site_index_i       (site_index_i),
    .sign_in_negative_i (sign_in_negative_i),
    .done_o             (done_o),
    .new_occupation_o   (new_occupation_o),
    .success_o          (success_o),
    .sign_out_negative_o(sign_out_negative_o)
  );

  always #4 clk_i = ~clk_i;

  // Index of the lowest set bit, 64 when none
  function automatic int unsigned lowest_set(logic [63:0] x);
    for (int unsigned k = 0; k < 64; k++) begin
      if (x[k]) return k;
    end
    return 64;
  endfunction

  // Parity of the first string's bits between the two lowest differing sites
  function automatic logic phase_sign(logic [63:0] u, logic [63:0] v);
    logic [63:0] diff;
    logic [63:0] rest;
    logic [63:0] between;
    int unsigned first;
    int unsigned gap;
    diff = (u ^ v) & SITE_MASK;
    if (diff == '0) return 1'b0;
    first = lowest_set(diff);
    if (first >= 63) return 1'b0;
    rest = diff >> (first + 1);
    if (rest == '0) return 1'b0;
    gap = lowest_set(rest);
    if (gap == 0) return 1'b0;
    between = (u >> (first + 1)) & ((64'd1 << gap) - 64'd1);
    return ^between;
  endfunction

  // Apply the operator of one command
  function automatic op_result_t apply_operator(occ_cmd_t c);
    op_result_t  r;
    logic [63:0] site_bit;
    r.occ      = c.occ;
    r.ok       = 1'b0;
    r.sign_neg = c.sign_neg;
    case (c.opcode)
      fosu_pkg::OP_ANNIHILATE, fosu_pkg::OP_CREATE: begin
        if (c.site < SITES) begin
          site_bit = 64'd1 << c.site;
          if (((c.occ & site_bit) != '0) == (c.opcode == fosu_pkg::OP_ANNIHILATE)) begin
            r.occ      = c.occ ^ site_bit;
            r.ok       = 1'b1;
            r.sign_neg = c.sign_neg ^ (^(c.occ & (site_bit - 64'd1)));
          end
        end
      end
      fosu_pkg::OP_PHASE: begin
        r.ok       = 1'b1;
        r.sign_neg = phase_sign(c.occ, c.other);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH @%0t %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_cmd(logic [1:0] op, logic [63:0] occ, logic [63:0] other,
                         logic [5:0] site, logic sign_neg);
    occ_cmd_t c;
    c.opcode      = op;
    c.occ         = occ;
    c.other       = other;
    c.site        = site;
    c.sign_neg    = sign_neg;
    c.pace        = 0;
    c.drain_first = 1'b0;
    cmd_q.push_back(c);
  endtask

  // Drive commands; record the prediction of every transfer
  always @(posedge clk_i or negedge rst_ni) begin
    occ_cmd_t nxt;
    bit       go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        result_q.push_back(apply_operator(cmd_q[0]));
        op_seen[cmd_q[0].opcode]++;
        void'(cmd_q.pop_front());
      end
      go = 1'b0;
      if (cmd_q.size() > 0) begin
        nxt = cmd_q[0];
        if (start && busy) begin
          // hold the refused command
          go = 1'b1;
        end else if (nxt.drain_first) begin
          // pause until every outstanding result is back
          if (result_q.size() == 0) begin
            cmd_q[0].drain_first = 1'b0;
            go = 1'b1;
          end
        end else begin
          go = ($urandom_range(99) >= idle_pct[nxt.pace]);
        end
      end
      start <= go;
      if (go) begin
        opcode_i           <= nxt.opcode;
        occupation_i       <= nxt.occ;
        other_occupation_i <= nxt.other;
        site_index_i       <= nxt.site;
        sign_in_negative_i <= nxt.sign_neg;
      end else begin
        // scramble the idle bus
        opcode_i           <= 2'($urandom);
        occupation_i       <= {$urandom, $urandom};
        other_occupation_i <= {$urandom, $urandom};
        site_index_i       <= 6'($urandom);
        sign_in_negative_i <= 1'($urandom);
      end
    end
  end

  // Check each result strobe against the oldest prediction
  always @(posedge clk_i) begin
    op_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", new_occupation_o, '0);
      end else begin
        want = result_q.pop_front();
        checked++;
        if (new_occupation_o !== want.occ)
          report_mismatch("new_occupation", new_occupation_o, want.occ);
        if (success_o !== want.ok)
          report_mismatch("success", 64'(success_o), 64'(want.ok));
        if (sign_out_negative_o !== want.sign_neg)
          report_mismatch("sign_out_negative", 64'(sign_out_negative_o),
                          64'(want.sign_neg));
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("fermion_operator_sign_unit verification failed");
      $finish;
    end
  end

  initial begin
    occ_cmd_t    c;
    int unsigned r;
    int unsigned p;
    int unsigned q;
    logic [63:0] bit_m;

    // Directed corner cases: ends of the string, failures, phase shapes
    add_cmd(fosu_pkg::OP_ANNIHILATE, 64'h1, '0, 6'd0, 1'b0);
    add_cmd(fosu_pkg::OP_ANNIHILATE, '1, '0, 6'd63, 1'b0);
    add_cmd(fosu_pkg::OP_ANNIHILATE, '1, '1, 6'd63, 1'b1);
    add_cmd(fosu_pkg::OP_CREATE, '0, '0, 6'd0, 1'b1);
    add_cmd(fosu_pkg::OP_CREATE, 64'h7FFF_FFFF_FFFF_FFFF, '0, 6'd63, 1'b0);
    add_cmd(fosu_pkg::OP_CREATE, '1, '0, 6'd17, 1'b1);
    add_cmd(fosu_pkg::OP_ANNIHILATE, '0, '1, 6'd40, 1'b1);
    add_cmd(fosu_pkg::OP_ANNIHILATE, 64'h8000_0000_0000_0000, '0, 6'd63, 1'b0);
    add_cmd(fosu_pkg::OP_CREATE, 64'h5, '0, 6'd3, 1'b0);
    add_cmd(fosu_pkg::OP_CREATE, 64'h1, '0, 6'd5, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, 64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5,
            6'd0, 1'b1);
    add_cmd(fosu_pkg::OP_PHASE, '0, 64'h10, 6'd0, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, '0, 64'h18, 6'd0, 1'b1);
    add_cmd(fosu_pkg::OP_PHASE, 64'hE, 64'h2F, 6'd9, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, 64'h6, 64'h27, 6'd9, 1'b1);
    add_cmd(fosu_pkg::OP_PHASE, '1, 64'h3FFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, '0, 64'h8000_0000_0000_0000, 6'd0, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, 64'h0000_0001_0000_0000, 64'h8000_0001_0000_0001,
            6'd0, 1'b0);
    add_cmd(fosu_pkg::OP_PHASE, 64'h7FFF_FFFF_FFFF_FFFE, '1, 6'd0, 1'b1);
    add_cmd(fosu_pkg::OP_NOP, '1, '1, 6'd63, 1'b1);
    add_cmd(fosu_pkg::OP_NOP, '0, '0, 6'd0, 1'b0);

    // Random commands in three pacing phases
    for (int unsigned i = 0; i < RANDOM_CMDS; i++) begin
      c.pace        = (i < 150) ? 0 : (i < 300) ? 1 : 2;
      c.drain_first = (i == 150) || (i == 300);
      c.sign_neg    = 1'($urandom);
      c.site        = 6'($urandom_range(63));
      c.other       = {$urandom, $urandom};
      r = $urandom_range(7);
      c.occ = (r == 0) ? '0 : (r == 1) ? '1 :
              (r == 2) ? ({$urandom, $urandom} & {$urandom, $urandom}) :
              {$urandom, $urandom};
      r = $urandom_range(99);
      c.opcode = (r < 35) ? fosu_pkg::OP_ANNIHILATE : (r < 70) ? fosu_pkg::OP_CREATE :
                 (r < 95) ? fosu_pkg::OP_PHASE : fosu_pkg::OP_NOP;
      if (c.opcode == fosu_pkg::OP_ANNIHILATE || c.opcode == fosu_pkg::OP_CREATE) begin
        // steer most operators to succeed
        bit_m = 64'd1 << c.site;
        if ($urandom_range(99) < 65)
          c.occ = (c.opcode == fosu_pkg::OP_ANNIHILATE) ?
                  (c.occ | bit_m) : (c.occ & ~bit_m);
      end else if (c.opcode == fosu_pkg::OP_PHASE) begin
        // shape the difference between the two strings
        p = $urandom_range(62);
        q = $urandom_range(63, p + 1);
        case ($urandom_range(5))
          0: c.other = c.occ;
          1: c.other = c.occ ^ (64'd1 << $urandom_range(63));
          2: c.other = c.occ ^ (64'd3 << p);
          3: c.other = c.occ ^ (64'd1 << p) ^ (64'd1 << q);
          4: c.other = c.occ ^ ({$urandom, $urandom} & {$urandom, $urandom}
                                & {$urandom, $urandom});
          default: ;
        endcase
      end
      cmd_q.push_back(c);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transfer and result, then let the pipeline settle
    while (cmd_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d results in %0d cycles: %0d annihilate, %0d create,",
             checked, cycle_cnt, op_seen[fosu_pkg::OP_ANNIHILATE],
             op_seen[fosu_pkg::OP_CREATE]);
    $display("%0d phase, %0d no-op commands; %0d mismatches",
             op_seen[fosu_pkg::OP_PHASE], op_seen[fosu_pkg::OP_NOP], mismatches);
    if (mismatches == 0) begin
      $display("fermion_operator_sign_unit verification clean");
    end else begin
      $display("fermion_operator_sign_unit verification failed");
    end
    $finish;
  end

endmodule

[fermion_operator_sign_unit.f]
+incdir+rtl
rtl/fosu_pkg.sv
rtl/fosu_parity_tree.sv
rtl/fermion_operator_sign_unit.sv
rtl/fosu_checker.sv
dv/testbench.sv
